FILE: hdl/udp_checksum_engine_top_assert.svh
// ---------------------------------------------------------------------------
// udp_checksum_engine_top_assert.svh
// Assertion macros shared by the checksum engine modules.
// ---------------------------------------------------------------------------
`ifndef UDP_CHECKSUM_ENGINE_TOP_ASSERT_SVH
`define UDP_CHECKSUM_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, gated by reset
`define UCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, gated by reset
`define UCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ucs_pkg.sv
// ---------------------------------------------------------------------------
// ucs_pkg
// Types and constants of the UDP checksum engine.
// ---------------------------------------------------------------------------
`default_nettype none

package ucs_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned SUM_W  = 32;
  // six 16-bit terms of the pseudo-header never exceed 19 bits
  localparam int unsigned SEED_W = 19;
  // word index only needs to tell 0..3 apart from "past the checksum field"
  localparam int unsigned IDX_W  = 3;

  localparam logic [WORD_W-1:0] UDP_PROTOCOL  = 16'd17;
  localparam logic [IDX_W-1:0]  CSUM_WORD_IDX = 3'd3;
  localparam logic [IDX_W-1:0]  IDX_SAT       = 3'd4;
  localparam logic [WORD_W-1:0] ODD_PAD_MASK  = 16'hFF00;
  localparam logic [WORD_W-1:0] FOLD_ALL_ONES = 16'hFFFF;

  localparam logic MODE_COMPUTE = 1'b0;
  localparam logic MODE_VERIFY  = 1'b1;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic              first;
    logic              last;
    logic              mode;
    logic [SEED_W-1:0] seed;
    logic [WORD_W-1:0] word;
  } entry_t;

endpackage

`default_nettype wire

FILE: hdl/ucs_front.sv
// ---------------------------------------------------------------------------
// ucs_front
// Accepts segment words, tracks segment position and mode, masks the
// checksum field (compute) and odd-length pad byte, builds pseudo-header seed.
// ---------------------------------------------------------------------------
`default_nettype none

module ucs_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_first_word,
  input  wire logic                       in_last_word,
  input  wire logic                       in_mode,
  input  wire logic [31:0]                in_source_address,
  input  wire logic [31:0]                in_destination_address,
  input  wire logic [15:0]                in_segment_length,
  input  wire logic [15:0]                in_data_word,
  input  wire logic                       q_full,
  output logic                            q_push,
  output ucs_pkg::entry_t                 q_push_data
);

  logic [ucs_pkg::IDX_W-1:0] idx_r, idx_nxt, idx_eff;
  logic                      mode_r, mode_nxt;
  logic                      odd_r, odd_nxt;
  logic [ucs_pkg::WORD_W-1:0] word_eff;
  logic [ucs_pkg::SEED_W-1:0] seed;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    seed = ucs_pkg::SEED_W'(in_source_address[31:16])
         + ucs_pkg::SEED_W'(in_source_address[15:0])
         + ucs_pkg::SEED_W'(in_destination_address[31:16])
         + ucs_pkg::SEED_W'(in_destination_address[15:0])
         + ucs_pkg::SEED_W'(ucs_pkg::UDP_PROTOCOL)
         + ucs_pkg::SEED_W'(in_segment_length);

    mode_nxt = in_first_word ? in_mode : mode_r;
    odd_nxt  = in_first_word ? in_segment_length[0] : odd_r;
    idx_eff  = in_first_word ? '0 : idx_r;

    word_eff = in_data_word;
    if (mode_nxt == ucs_pkg::MODE_COMPUTE && idx_eff == ucs_pkg::CSUM_WORD_IDX) begin
      word_eff = '0;
    end
    if (in_last_word && odd_nxt) begin
      word_eff = word_eff & ucs_pkg::ODD_PAD_MASK;
    end

    if (in_last_word) begin
      idx_nxt = '0;
    end else if (idx_eff == ucs_pkg::IDX_SAT) begin
      idx_nxt = idx_eff;
    end else begin
      idx_nxt = idx_eff + 1'b1;
    end

    q_push_data.first = in_first_word;
    q_push_data.last  = in_last_word;
    q_push_data.mode  = mode_nxt;
    q_push_data.seed  = seed;
    q_push_data.word  = word_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      mode_r <= ucs_pkg::MODE_COMPUTE;
      odd_r  <= 1'b0;
    end else if (q_push) begin
      idx_r  <= idx_nxt;
      mode_r <= mode_nxt;
      odd_r  <= odd_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ucs_queue.sv
// ---------------------------------------------------------------------------
// ucs_queue
// Small first-word-fall-through queue between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module ucs_queue #(
  parameter int unsigned Depth = ucs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire ucs_pkg::entry_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 pop_valid,
  output ucs_pkg::entry_t      pop_data
);

  `include "udp_checksum_engine_top_assert.svh"

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  ucs_pkg::entry_t mem [Depth];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(Depth));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  `UCS_ASSERT_IMP(a_no_push_full, full, !push, "queue written while full")
  `UCS_ASSERT_IMP(a_no_pop_empty, !pop_valid, !pop, "queue read while empty")
  `UCS_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(Depth), "queue count beyond depth")

endmodule

`default_nettype wire

FILE: hdl/ucs_back.sv
// ---------------------------------------------------------------------------
// ucs_back
// Accumulates queued words onto the running sum, then folds and
// complements the finished sum into the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module ucs_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire ucs_pkg::entry_t             q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ucs_pkg::WORD_W-1:0]       out_checksum,
  output logic                             out_checksum_ok
);

  `include "udp_checksum_engine_top_assert.svh"

  logic [ucs_pkg::SUM_W-1:0]  sum_r, sum_nxt, acc;
  logic                       fin_v_r;
  logic [ucs_pkg::SUM_W-1:0]  fin_sum_r;
  logic                       fin_mode_r;
  logic                       out_valid_r;
  logic [ucs_pkg::WORD_W-1:0] out_checksum_r;
  logic                       out_ok_r;
  logic                       out_move, fin_move, fin_free;
  logic [ucs_pkg::WORD_W:0]   fold1;
  logic [ucs_pkg::WORD_W-1:0] fold2;

  assign out_move = !out_valid_r || !out_stall;
  assign fin_move = fin_v_r && out_move;
  assign fin_free = !fin_v_r || out_move;
  assign q_pop    = q_valid && (!q_data.last || fin_free);

  always_comb begin
    acc = (q_data.first ? ucs_pkg::SUM_W'(q_data.seed) : sum_r)
        + ucs_pkg::SUM_W'(q_data.word);
    sum_nxt = sum_r;
    if (q_pop) begin
      sum_nxt = q_data.last ? '0 : acc;
    end
    // two end-around folds of the finished sum
    fold1 = (ucs_pkg::WORD_W + 1)'(fin_sum_r[31:16])
          + (ucs_pkg::WORD_W + 1)'(fin_sum_r[15:0]);
    fold2 = ucs_pkg::WORD_W'(fold1[15:0] + ucs_pkg::WORD_W'(fold1[16]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      fin_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      if (q_pop && q_data.last) begin
        fin_v_r <= 1'b1;
      end else if (fin_move) begin
        fin_v_r <= 1'b0;
      end
      if (fin_move) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      fin_sum_r  <= acc;
      fin_mode_r <= q_data.mode;
    end
    if (fin_move) begin
      out_checksum_r <= ~fold2;
      out_ok_r       <= (fin_mode_r == ucs_pkg::MODE_VERIFY)
                        && (fold2 == ucs_pkg::FOLD_ALL_ONES);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_checksum    = out_checksum_r;
  assign out_checksum_ok = out_ok_r;

  `UCS_ASSERT_NXT(a_sum_cleared, q_pop && q_data.last, sum_r == '0,
    "running sum not cleared after last word")
  `UCS_ASSERT_IMP(a_fin_no_overrun, fin_v_r && !out_move, !(q_pop && q_data.last),
    "finished sum overwritten while held")
  `UCS_ASSERT_IMP(a_ok_means_zero, out_valid_r && out_ok_r, out_checksum_r == '0,
    "pass flag set with nonzero checksum")

endmodule

`default_nettype wire

FILE: hdl/udp_checksum_engine_top.sv
// ---------------------------------------------------------------------------
// udp_checksum_engine_top
// UDP checksum, IPv4 pseudo-header, one 16-bit word per cycle unless stalled.
// ---------------------------------------------------------------------------
// Takes one segment word per cycle unless in_stall is high; the first word
// of a segment also carries the addresses, UDP length and mode (0 compute,
// 1 verify). The rate is set by the 32-bit accumulator adder in the back
// part, which retires one queued word per cycle unless a last word waits
// for the result path. The result (checksum and pass flag) is registered;
// a small queue and a two-deep result path let either side stall on its own.
`default_nettype none

module udp_checksum_engine_top #(
  parameter int unsigned QueueDepth = ucs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_first_word,
  input  wire logic        in_last_word,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_source_address,
  input  wire logic [31:0] in_destination_address,
  input  wire logic [15:0] in_segment_length,
  input  wire logic [15:0] in_data_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_checksum,
  output logic             out_checksum_ok
);

  logic            q_full, q_push, q_pop, q_valid;
  ucs_pkg::entry_t q_push_data, q_data;

  ucs_front u_front (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_first_word          (in_first_word),
    .in_last_word           (in_last_word),
    .in_mode                (in_mode),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .in_segment_length      (in_segment_length),
    .in_data_word           (in_data_word),
    .q_full                 (q_full),
    .q_push                 (q_push),
    .q_push_data            (q_push_data)
  );

  ucs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  ucs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_checksum    (out_checksum),
    .out_checksum_ok (out_checksum_ok)
  );

endmodule

`default_nettype wire

FILE: tb/tb_udp_checksum_engine_top.sv
// ---------------------------------------------------------------------------
// tb_udp_checksum_engine_top
// Self-checking bench for the UDP checksum engine.
// ---------------------------------------------------------------------------
// Segments go in one 16-bit word per transaction. A bit-accurate predictor
// follows every accepted word (pseudo-header seed, checksum-field zeroing,
// odd-length padding, double fold) and queues the checksum it expects. Each
// result transaction is checked against the oldest queued checksum. The input
// side sends in bursts with random gaps; the result side stalls on a phase
// pattern of its own, with one long hold-off to back the engine up.
// ---------------------------------------------------------------------------
module tb_udp_checksum_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] checksum;
    logic        ok;
  } csum_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_first_word;
  logic        in_last_word;
  logic        in_mode;
  logic [31:0] in_source_address;
  logic [31:0] in_destination_address;
  logic [15:0] in_segment_length;
  logic [15:0] in_data_word;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_checksum;
  logic        out_checksum_ok;

  // predictor state
  logic [31:0] seg_sum;
  logic [15:0] seg_idx;
  logic        seg_mode;
  logic        seg_odd;
  csum_result_t expected_sums[$];
  csum_result_t oldest_sum;

  int  mismatches;
  int  words_sent;
  int  segments_sent;
  int  sums_checked;
  int  verify_passes;
  int  burst_left;
  bit  gaps_on;
  bit  hold_kick;

  // result-side stall generator
  bit  hold_seen;
  int  hold_left;
  int  phase_left;
  int  stall_pct;

  udp_checksum_engine_top dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_first_word          (in_first_word),
    .in_last_word           (in_last_word),
    .in_mode                (in_mode),
    .in_source_address      (in_source_address),
    .in_destination_address (in_destination_address),
    .in_segment_length      (in_segment_length),
    .in_data_word           (in_data_word),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_checksum           (out_checksum),
    .out_checksum_ok        (out_checksum_ok)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  function automatic void accumulate_word(input logic first, input logic last,
                                          input logic mode, input logic [31:0] src,
                                          input logic [31:0] dst, input logic [15:0] len,
                                          input logic [15:0] word);
    logic [15:0]  w;
    logic [31:0]  folded;
    csum_result_t r;
    if (first) begin
      seg_sum  = 32'(src[31:16]) + 32'(src[15:0]) + 32'(dst[31:16]) + 32'(dst[15:0])
               + 32'(ucs_pkg::UDP_PROTOCOL) + 32'(len);
      seg_idx  = '0;
      seg_mode = mode;
      seg_odd  = len[0];
    end
    w = word;
    // checksum field counts as zero while computing
    if (seg_mode == ucs_pkg::MODE_COMPUTE && seg_idx == 16'(ucs_pkg::CSUM_WORD_IDX)) w = '0;
    if (last && seg_odd) w &= ucs_pkg::ODD_PAD_MASK;
    seg_sum += 32'(w);
    if (seg_idx != 16'hFFFF) seg_idx++;
    if (last) begin
      folded     = 32'(seg_sum[31:16]) + 32'(seg_sum[15:0]);
      folded     = 32'(folded[31:16]) + 32'(folded[15:0]);
      r.checksum = ~folded[15:0];
      r.ok       = (seg_mode == ucs_pkg::MODE_VERIFY)
                   && (folded[15:0] == ucs_pkg::FOLD_ALL_ONES);
      expected_sums.push_back(r);
      seg_sum = '0;
      seg_idx = '0;
    end
  endfunction

  // input monitor feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      accumulate_word(in_first_word, in_last_word, in_mode, in_source_address,
                      in_destination_address, in_segment_length, in_data_word);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        flag_mismatch($sformatf("result %h ok=%b with nothing expected",
                                out_checksum, out_checksum_ok));
      end else begin
        oldest_sum = expected_sums.pop_front();
        sums_checked++;
        if (out_checksum !== oldest_sum.checksum)
          flag_mismatch($sformatf("checksum %h, expected %h", out_checksum,
                                  oldest_sum.checksum));
        if (out_checksum_ok !== oldest_sum.ok)
          flag_mismatch($sformatf("checksum_ok %b, expected %b (checksum %h)",
                                  out_checksum_ok, oldest_sum.ok, oldest_sum.checksum));
        if (oldest_sum.ok) verify_passes++;
      end
    end
  end

  // result side: random stall phases, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      hold_seen  <= 1'b0;
      hold_left  <= 0;
      phase_left <= 0;
      stall_pct  <= 0;
    end else if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (phase_left == 0) begin
      phase_left <= $urandom_range(20, 120);
      stall_pct  <= 30 * $urandom_range(0, 3);
      out_stall  <= 1'b0;
    end else begin
      phase_left <= phase_left - 1;
      out_stall  <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_word(input logic first, input logic last, input logic mode,
                           input logic [31:0] src, input logic [31:0] dst,
                           input logic [15:0] len, input logic [15:0] word);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid               <= 1'b1;
    in_first_word          <= first;
    in_last_word           <= last;
    in_mode                <= mode;
    in_source_address      <= src;
    in_destination_address <= dst;
    in_segment_length      <= len;
    in_data_word           <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  // one well-formed segment of n words; with seal set and n above 4, the
  // checksum field is filled so that a verify pass succeeds
  task automatic send_segment(input logic mode, input logic [31:0] src,
                              input logic [31:0] dst, input logic [15:0] len,
                              input int n, input bit seal);
    logic [15:0] words[$];
    logic [31:0] acc;
    logic [15:0] w;
    for (int i = 0; i < n; i++) words.push_back(16'($urandom));
    if (seal && n > 4) begin
      acc = 32'(src[31:16]) + 32'(src[15:0]) + 32'(dst[31:16]) + 32'(dst[15:0])
          + 32'(ucs_pkg::UDP_PROTOCOL) + 32'(len);
      for (int i = 0; i < n; i++) begin
        if (i != int'(ucs_pkg::CSUM_WORD_IDX)) begin
          w = words[i];
          if (i == n - 1 && len[0]) w &= ucs_pkg::ODD_PAD_MASK;
          acc += 32'(w);
        end
      end
      acc = 32'(acc[31:16]) + 32'(acc[15:0]);
      acc = 32'(acc[31:16]) + 32'(acc[15:0]);
      words[ucs_pkg::CSUM_WORD_IDX] = ~acc[15:0];
    end
    // header fields on later words must be ignored, so scramble them
    for (int i = 0; i < n; i++) begin
      if (i == 0) send_word(1'b1, n == 1, mode, src, dst, len, words[i]);
      else send_word(1'b0, i == n - 1, 1'($urandom), $urandom, $urandom, 16'($urandom),
                     words[i]);
    end
    segments_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_no_first_word();
    // straight out of reset: zero seed, compute mode, even length latched
    send_word(1'b0, 1'b0, ucs_pkg::MODE_VERIFY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
              16'h1234);
    send_word(1'b0, 1'b0, ucs_pkg::MODE_VERIFY, '0, '0, '0, 16'hFFFF);
    send_word(1'b0, 1'b0, ucs_pkg::MODE_VERIFY, '0, '0, '0, 16'h00FF);
    send_word(1'b0, 1'b1, ucs_pkg::MODE_VERIFY, '0, '0, '0, 16'hABCD);
    drain_results();
  endtask

  task automatic test_field_extremes();
    send_word(1'b1, 1'b1, ucs_pkg::MODE_COMPUTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
              16'hFFFF);
    send_word(1'b1, 1'b1, ucs_pkg::MODE_VERIFY, '0, '0, '0, '0);
    send_word(1'b1, 1'b1, ucs_pkg::MODE_VERIFY, 32'hFFFF_FFFF, '0, 16'hFFFE, 16'hFFFF);
    send_word(1'b1, 1'b1, ucs_pkg::MODE_COMPUTE, '0, 32'hFFFF_FFFF, 16'h0001, 16'h80FF);
    drain_results();
  endtask

  task automatic test_modes();
    send_segment(ucs_pkg::MODE_COMPUTE, 32'hC0A8_0001, 32'hC0A8_00C7, 16'd8, 4, 1'b0);
    send_segment(ucs_pkg::MODE_VERIFY, 32'h0A00_0001, 32'h0A00_0002, 16'd11, 6, 1'b1);
    send_segment(ucs_pkg::MODE_VERIFY, 32'h0A00_0003, 32'h0A00_0004, 16'd12, 6, 1'b0);
    // orphan words after a segment keep its latched mode and parity
    send_word(1'b0, 1'b0, ucs_pkg::MODE_COMPUTE, '0, '0, '0, 16'h5A5A);
    send_word(1'b0, 1'b1, ucs_pkg::MODE_COMPUTE, '0, '0, '0, 16'hA5A5);
    drain_results();
  endtask

  task automatic test_restart();
    // a new first word in mid-segment reseeds everything
    send_word(1'b1, 1'b0, ucs_pkg::MODE_VERIFY, 32'h1111_2222, 32'h3333_4444, 16'd9,
              16'h0101);
    send_word(1'b0, 1'b0, ucs_pkg::MODE_VERIFY, '0, '0, '0, 16'h0202);
    send_word(1'b1, 1'b0, ucs_pkg::MODE_COMPUTE, 32'h5555_6666, 32'h7777_8888, 16'd20,
              16'h0303);
    send_word(1'b0, 1'b0, ucs_pkg::MODE_VERIFY, '0, '0, '0, 16'h0404);
    send_word(1'b0, 1'b1, ucs_pkg::MODE_VERIFY, '0, '0, '0, 16'h0505);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int target;
    int kind;
    int n;
    logic [15:0] len;
    logic        mode;
    target = words_sent + 490;
    while (words_sent < target) begin
      kind = $urandom_range(0, 99);
      mode = 1'($urandom);
      if (kind < 60) begin
        len = 16'($urandom_range(8, 72));
        n   = (int'(len) + 1) / 2;
        send_segment(mode, $urandom, $urandom, len, n, $urandom_range(0, 9) < 7);
      end else if (kind < 75) begin
        send_segment(mode, $urandom, $urandom, 16'($urandom), $urandom_range(1, 12),
                     $urandom_range(0, 1));
      end else if (kind < 85) begin
        send_segment(mode, $urandom, $urandom, 16'($urandom), 1, 1'b0);
      end else begin
        send_word(1'($urandom), 1'($urandom), mode, $urandom, $urandom, 16'($urandom),
                  16'($urandom));
      end
    end
    // close any segment left open by noise
    send_word(1'b0, 1'b1, ucs_pkg::MODE_COMPUTE, '0, '0, '0, 16'($urandom));
    drain_results();
  endtask

  task automatic test_backpressure();
    gaps_on   = 1'b0;
    hold_kick <= ~hold_kick;
    for (int i = 0; i < 12; i++) begin
      send_segment(1'($urandom), $urandom, $urandom, 16'($urandom), $urandom_range(1, 3),
                   1'b0);
    end
    gaps_on = 1'b1;
    drain_results();
  endtask

  initial begin
    rst_n                  = 1'b0;
    in_valid               = 1'b0;
    in_first_word          = 1'b0;
    in_last_word           = 1'b0;
    in_mode                = 1'b0;
    in_source_address      = '0;
    in_destination_address = '0;
    in_segment_length      = '0;
    in_data_word           = '0;
    hold_kick              = 1'b0;
    gaps_on                = 1'b1;
    burst_left             = 0;
    seg_sum                = '0;
    seg_idx                = '0;
    seg_mode               = ucs_pkg::MODE_COMPUTE;
    seg_odd                = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_first_word();
    test_field_extremes();
    test_modes();
    test_restart();
    test_backpressure();
    test_random_traffic();

    $display("Sent %0d words in %0d segments, with stray and restarted words mixed in.",
             words_sent, segments_sent);
    $display("Checked %0d checksums (%0d verify passes), %0d errors.", sums_checked,
             verify_passes, mismatches);
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("udp_checksum_engine_top: match");
    end else begin
      $display("udp_checksum_engine_top: mismatch");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out with %0d checksums outstanding.", expected_sums.size());
    $display("udp_checksum_engine_top: mismatch");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/ucs_pkg.sv
hdl/ucs_front.sv
hdl/ucs_queue.sv
hdl/ucs_back.sv
hdl/udp_checksum_engine_top.sv
tb/tb_udp_checksum_engine_top.sv
